/* hw/rtl/dcs_pkg.sv */
// Package for the divisor count and sum unit: result widths, saturation limits,
// controller states, and the command and status structs between controller and datapath.
// No dependencies.
package dcs_pkg;

    localparam int COUNT_BITS = 12;
    localparam int SUM_BITS   = 34;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL_TERM,
        ST_MUL_SUM,
        ST_LEFT,
        ST_MUL_LEFT,
        ST_FINISH
    } dcs_state_t;

    typedef enum logic [1:0] {
        MUL_TERM_CAND,
        MUL_SUM_TERM,
        MUL_SUM_LEFT
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     take_quot;
        logic     term_update;
        logic     sum_update;
        logic     count_by_exp;
        logic     count_by_two;
        logic     next_cand;
        logic     out_load;
    } dcs_cmd_t;

    typedef struct packed {
        logic sq_above;
        logic rem_zero;
        logic exp_found;
        logic n_above_one;
        logic div_done;
        logic mul_done;
    } dcs_sts_t;

endpackage

/* hw/rtl/dcs_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module dcs_div #(
    parameter int DIVIDEND_BITS = 31,
    parameter int DIVISOR_BITS  = 17
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic [DIVIDEND_BITS-1:0] quotient,
    output logic [DIVISOR_BITS-1:0]  remainder,
    output logic                     done
);

    localparam int CNT_W = $clog2(DIVIDEND_BITS);

    logic                     busy_reg;
    logic                     done_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  dsr_reg;
    logic [DIVIDEND_BITS-1:0] quo_reg;

    logic [DIVISOR_BITS:0]    shifted;
    logic [DIVISOR_BITS:0]    diff;
    logic                     ge;
    logic [DIVISOR_BITS-1:0]  rem_next;

    always_comb begin
        shifted  = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        ge       = shifted >= {1'b0, dsr_reg};
        diff     = shifted - {1'b0, dsr_reg};
        rem_next = ge ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(DIVIDEND_BITS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= '0;
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], ge};
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

/* hw/rtl/dcs_mul.sv */
// Saturating shift-and-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on dcs_pkg for the sum width and its saturation limit.
module dcs_mul
    import dcs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [SUM_BITS-1:0] op_a,
    input  logic [SUM_BITS-1:0] op_b,
    output logic [SUM_BITS-1:0] product,
    output logic                done
);

    localparam int CNT_W = $clog2(SUM_BITS);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SUM_BITS-1:0] a_reg;
    logic [SUM_BITS-1:0] b_reg;
    logic [SUM_BITS-1:0] acc_reg;

    logic [SUM_BITS+1:0] step;
    logic [SUM_BITS-1:0] acc_next;

    always_comb begin
        step = {1'b0, acc_reg, 1'b0}
             + (b_reg[SUM_BITS-1] ? {2'b00, a_reg} : {(SUM_BITS+2){1'b0}});
        acc_next = (step > {2'b00, SUM_MAX}) ? SUM_MAX : step[SUM_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(SUM_BITS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= '0;
            a_reg   <= op_a;
            b_reg   <= op_b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            b_reg   <= {b_reg[SUM_BITS-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

    assign product = acc_reg;
    assign done    = done_reg;

endmodule

/* hw/rtl/dcs_datapath.sv */
// Datapath: remaining value, candidate and its square, running count, sum and
// prime-power term, plus the shared divider and multiplier and the result register.
// Depends on dcs_pkg, dcs_div and dcs_mul.
module dcs_datapath
    import dcs_pkg::*;
#(
    parameter int VALUE_BITS = 31
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dcs_cmd_t              cmd,
    output dcs_sts_t              sts,
    input  logic [VALUE_BITS-1:0] s_value,
    output logic [COUNT_BITS-1:0] m_divisor_count,
    output logic [SUM_BITS-1:0]   m_divisor_sum
);

    localparam int CAND_BITS = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQ_BITS   = VALUE_BITS + 1;
    localparam int EP_BITS   = $clog2(VALUE_BITS + 2);
    localparam int NP1_BITS  = (VALUE_BITS > SUM_BITS) ? VALUE_BITS + 1 : SUM_BITS + 1;
    localparam int CP_BITS   = COUNT_BITS + EP_BITS;

    logic [VALUE_BITS-1:0] n_reg,     n_next;
    logic [CAND_BITS-1:0]  cand_reg,  cand_next;
    logic [SQ_BITS-1:0]    sq_reg,    sq_next;
    logic [EP_BITS-1:0]    ep1_reg,   ep1_next;
    logic [SUM_BITS-1:0]   term_reg,  term_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [SUM_BITS-1:0]   sum_reg,   sum_next;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic [SUM_BITS-1:0]   out_sum_reg;

    logic [VALUE_BITS-1:0] quotient;
    logic [CAND_BITS-1:0]  remainder;
    logic                  div_done;
    logic [SUM_BITS-1:0]   product;
    logic                  mul_done;
    logic [SUM_BITS-1:0]   mul_a;
    logic [SUM_BITS-1:0]   mul_b;

    logic [NP1_BITS-1:0]   n_plus;
    logic [SUM_BITS-1:0]   n_plus_sat;
    logic [EP_BITS-1:0]    count_factor;
    logic [CP_BITS-1:0]    count_prod;
    logic [COUNT_BITS-1:0] count_sat;
    logic                  nonzero;

    dcs_div #(
        .DIVIDEND_BITS(VALUE_BITS),
        .DIVISOR_BITS (CAND_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (n_reg),
        .divisor  (cand_reg),
        .quotient (quotient),
        .remainder(remainder),
        .done     (div_done)
    );

    dcs_mul u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.mul_start),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .product(product),
        .done   (mul_done)
    );

    always_comb begin
        n_plus     = NP1_BITS'(n_reg) + NP1_BITS'(1);
        n_plus_sat = (n_plus >= NP1_BITS'(SUM_MAX)) ? SUM_MAX : n_plus[SUM_BITS-1:0];

        case (cmd.mul_sel)
            MUL_TERM_CAND: begin
                mul_a = term_reg;
                mul_b = SUM_BITS'(cand_reg);
            end
            MUL_SUM_TERM: begin
                mul_a = sum_reg;
                mul_b = term_reg;
            end
            MUL_SUM_LEFT: begin
                mul_a = sum_reg;
                mul_b = n_plus_sat;
            end
            default: begin
                mul_a = sum_reg;
                mul_b = term_reg;
            end
        endcase

        count_factor = cmd.count_by_two ? EP_BITS'(2) : ep1_reg;
        count_prod   = CP_BITS'(count_reg) * CP_BITS'(count_factor);
        count_sat    = (count_prod > CP_BITS'(COUNT_MAX)) ? COUNT_MAX
                                                          : count_prod[COUNT_BITS-1:0];
        nonzero      = s_value != '0;
    end

    always_comb begin
        n_next     = n_reg;
        cand_next  = cand_reg;
        sq_next    = sq_reg;
        ep1_next   = ep1_reg;
        term_next  = term_reg;
        count_next = count_reg;
        sum_next   = sum_reg;

        if (cmd.load) begin
            n_next     = s_value;
            cand_next  = CAND_BITS'(2);
            sq_next    = SQ_BITS'(4);
            ep1_next   = EP_BITS'(1);
            term_next  = SUM_BITS'(1);
            count_next = COUNT_BITS'(nonzero);
            sum_next   = SUM_BITS'(nonzero);
        end else begin
            if (cmd.take_quot) begin
                n_next   = quotient;
                ep1_next = ep1_reg + 1'b1;
            end
            if (cmd.term_update) begin
                term_next = (product == SUM_MAX) ? SUM_MAX : product + 1'b1;
            end
            if (cmd.count_by_exp || cmd.count_by_two) begin
                count_next = count_sat;
            end
            if (cmd.sum_update) begin
                sum_next = product;
            end
            if (cmd.next_cand) begin
                cand_next = cand_reg + 1'b1;
                sq_next   = sq_reg + SQ_BITS'({cand_reg, 1'b1});
                ep1_next  = EP_BITS'(1);
                term_next = SUM_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        cand_reg  <= cand_next;
        sq_reg    <= sq_next;
        ep1_reg   <= ep1_next;
        term_reg  <= term_next;
        count_reg <= count_next;
        sum_reg   <= sum_next;
        if (cmd.out_load) begin
            out_count_reg <= count_reg;
            out_sum_reg   <= sum_reg;
        end
    end

    always_comb begin
        sts.sq_above    = sq_reg > SQ_BITS'(n_reg);
        sts.rem_zero    = remainder == '0;
        sts.exp_found   = ep1_reg > EP_BITS'(1);
        sts.n_above_one = n_reg > VALUE_BITS'(1);
        sts.div_done    = div_done;
        sts.mul_done    = mul_done;
    end

    assign m_divisor_count = out_count_reg;
    assign m_divisor_sum   = out_sum_reg;

endmodule

/* hw/rtl/dcs_ctrl.sv */
// Controller state machine that sequences the trial division and the handshakes.
// Depends on dcs_pkg for the state enum and the command and status structs.
module dcs_ctrl
    import dcs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dcs_sts_t sts,
    output dcs_cmd_t cmd
);

    dcs_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = sts.sq_above ? ST_LEFT : ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    if (sts.rem_zero)       state_next = ST_MUL_TERM;
                    else if (sts.exp_found) state_next = ST_MUL_SUM;
                    else                    state_next = ST_CHECK;
                end
            end
            ST_MUL_TERM: begin
                if (sts.mul_done) state_next = ST_DIV;
            end
            ST_MUL_SUM: begin
                if (sts.mul_done) state_next = ST_CHECK;
            end
            ST_LEFT: begin
                state_next = sts.n_above_one ? ST_MUL_LEFT : ST_FINISH;
            end
            ST_MUL_LEFT: begin
                if (sts.mul_done) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_CHECK: begin
                cmd.div_start = !sts.sq_above;
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    if (sts.rem_zero) begin
                        cmd.take_quot = 1'b1;
                        cmd.mul_start = 1'b1;
                        cmd.mul_sel   = MUL_TERM_CAND;
                    end else if (sts.exp_found) begin
                        cmd.count_by_exp = 1'b1;
                        cmd.mul_start    = 1'b1;
                        cmd.mul_sel      = MUL_SUM_TERM;
                    end else begin
                        cmd.next_cand = 1'b1;
                    end
                end
            end
            ST_MUL_TERM: begin
                cmd.term_update = sts.mul_done;
                cmd.div_start   = sts.mul_done;
            end
            ST_MUL_SUM: begin
                cmd.sum_update = sts.mul_done;
                cmd.next_cand  = sts.mul_done;
            end
            ST_LEFT: begin
                cmd.count_by_two = sts.n_above_one;
                cmd.mul_start    = sts.n_above_one;
                cmd.mul_sel      = MUL_SUM_LEFT;
            end
            ST_MUL_LEFT: begin
                cmd.sum_update = sts.mul_done;
            end
            ST_FINISH: begin
                cmd.out_load = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

/* hw/rtl/divisor_count_and_sum_unit.sv */
// Top level of the divisor count and sum unit: controller plus datapath.
// Depends on dcs_pkg, dcs_ctrl and dcs_datapath.
//
// Each request carries a positive integer; the unit returns the number of its
// divisors and their exact sum, found by trial division with candidates 2, 3, ...
// while the candidate squared does not exceed the unfactored part. A value of zero
// returns a count and sum of zero. One request is processed at a time. Every
// candidate costs one pass of the bit-serial divider. Each occurrence of a prime
// factor adds one multiply and one more divider pass, and each distinct prime
// adds one more multiply. A finished result waits in the output register while
// the next request is accepted.
module divisor_count_and_sum_unit
    import dcs_pkg::*;
#(
    parameter int VALUE_BITS = 31
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COUNT_BITS-1:0] m_divisor_count,
    output logic [SUM_BITS-1:0]   m_divisor_sum
);

    dcs_cmd_t cmd;
    dcs_sts_t sts;

    dcs_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    dcs_datapath #(
        .VALUE_BITS(VALUE_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_value        (s_value),
        .m_divisor_count(m_divisor_count),
        .m_divisor_sum  (m_divisor_sum)
    );

endmodule

/* hw/rtl/dcs_checker.sv */
// Port-level checks for the divisor count and sum unit, bound to its top level.
// Depends on dcs_pkg for the result widths.
module dcs_checker
    import dcs_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [COUNT_BITS-1:0] m_divisor_count,
    input logic [SUM_BITS-1:0]   m_divisor_sum
);

    // A stalled result keeps its valid and its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_divisor_count)
                                && $stable(m_divisor_sum))
        else $error("stalled result changed");

    // Only a zero value gives a zero count, and the sum is zero exactly when the count is.
    a_zero_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_divisor_count == '0) == (m_divisor_sum == '0)))
        else $error("count and sum disagree on the zero code");

    // A single divisor means the value was one.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divisor_count == COUNT_BITS'(1) |-> m_divisor_sum == SUM_BITS'(1))
        else $error("count of one with a sum other than one");

    // Distinct positive divisors always add up to more than their number.
    a_sum_exceeds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divisor_count > COUNT_BITS'(1)
            |-> m_divisor_sum > SUM_BITS'(m_divisor_count))
        else $error("divisor sum not above divisor count");

    // The unit leaves reset ready for a request with no result pending.
    a_reset_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> s_ready && !m_valid)
        else $error("unit not idle after reset");

endmodule

bind divisor_count_and_sum_unit dcs_checker u_dcs_checker (.*);
